@@ sv/cpu_pkg.sv @@
`default_nettype none
package cpu_pkg;

	localparam logic [15:0] RESET_VECTOR = 16'hFFFC;
	localparam logic [15:0] BREAK_VECTOR = 16'hFFFE;
	localparam logic [7:0]  STACK_PAGE   = 8'h01;
	localparam logic [7:0]  SP_RESET     = 8'hFF;

	localparam int FL_C = 0;
	localparam int FL_Z = 1;
	localparam int FL_I = 2;
	localparam int FL_D = 3;
	localparam int FL_B = 4;
	localparam int FL_U = 5;
	localparam int FL_V = 6;
	localparam int FL_N = 7;

	localparam logic [7:0] OPC_PHA = 8'h48;
	localparam logic [7:0] OPC_PLA = 8'h68;
	localparam logic [7:0] OPC_RTI = 8'h40;
	localparam logic [7:0] OPC_JSR = 8'h20;
	localparam logic [7:0] OPC_STA_IMM = 8'h89;

	typedef enum logic [3:0] {
		M_IMP, M_ACC, M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABX, M_ABY,
		M_IZX, M_IZY, M_IND, M_REL, M_NONE
	} mode_t;

	typedef enum logic [4:0] {
		OP_ORA = 5'd0, OP_AND = 5'd1, OP_EOR = 5'd2, OP_ADC = 5'd3, OP_STA = 5'd4,
		OP_LDA = 5'd5, OP_CMP = 5'd6, OP_SBC = 5'd7, OP_ASL = 5'd8, OP_ROL = 5'd9,
		OP_LSR = 5'd10, OP_ROR = 5'd11, OP_STX = 5'd12, OP_LDX = 5'd13,
		OP_DEC = 5'd14, OP_INC = 5'd15, OP_BIT = 5'd16, OP_STY = 5'd17,
		OP_LDY = 5'd18, OP_CPY = 5'd19, OP_CPX = 5'd20, OP_JMP = 5'd21,
		OP_BRANCH = 5'd22, OP_IMPL = 5'd23, OP_PUSH = 5'd24, OP_PULL = 5'd25,
		OP_BRK = 5'd26, OP_JSR = 5'd27, OP_RTI = 5'd28, OP_RTS = 5'd29,
		OP_ILL = 5'd30
	} op_t;

	typedef enum logic [3:0] {
		ST_START, ST_VLO, ST_VHI, ST_OPC, ST_OP1, ST_OP2, ST_PLO, ST_PHI,
		ST_DATA, ST_FIN, ST_PULL, ST_RLO, ST_RHI, ST_BVEC, ST_PUSHLO, ST_PUSHP
	} step_t;

	typedef struct packed {
		logic [7:0]  a;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [7:0]  sp;
		logic [7:0]  p;
		logic [15:0] pc;
		logic [7:0]  opc;
		logic [15:0] ea;
		logic [7:0]  opb;
		step_t       step;
		logic        halt;
	} cpu_state_t;

	typedef struct packed {
		logic [15:0] bus_address;
		logic        write_en;
		logic [7:0]  write_data;
		logic        instruction_done;
		logic        halted_illegal;
	} bus_req_t;

	localparam cpu_state_t STATE_RESET = '{
		a: 8'h00, x: 8'h00, y: 8'h00, sp: SP_RESET, p: 8'h20, pc: 16'h0000,
		opc: 8'h00, ea: 16'h0000, opb: 8'h00, step: ST_START, halt: 1'b0
	};

endpackage
`default_nettype wire

@@ sv/cpu_in_if.sv @@
`default_nettype none
interface cpu_in_if;
	logic       valid;
	logic       ready;
	logic       restart;
	logic [7:0] read_data;
	modport source (output valid, restart, read_data, input ready);
	modport sink (input valid, restart, read_data, output ready);
endinterface
`default_nettype wire

@@ sv/cpu_out_if.sv @@
`default_nettype none
interface cpu_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] bus_address;
	logic        write_en;
	logic [7:0]  write_data;
	logic        instruction_done;
	logic        halted_illegal;
	modport source (output valid, bus_address, write_en, write_data, instruction_done,
		halted_illegal, input ready);
	modport sink (input valid, bus_address, write_en, write_data, instruction_done,
		halted_illegal, output ready);
endinterface
`default_nettype wire

@@ sv/cpu6502_instruction_core.sv @@
`default_nettype none
// Channel   Role   Beat carries
// in_ch     sink   restart, read_data (answer to the previous read)
// out_ch    source bus_address, write_en, write_data, instruction_done, halted_illegal
//
// One input beat gives exactly one output beat, one bus access per beat.
// The whole access step (decode, ALU, address add) is evaluated combinationally
// between the architectural registers and the output register.
// Reset empties the output register; the state restarts at the reset-vector fetch.
// A waiting output beat blocks input until it drains: a new beat is taken whenever
// the output register is empty or is being drained in the same cycle.
module cpu6502_instruction_core import cpu_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	cpu_in_if.sink     in_ch,
	cpu_out_if.source  out_ch
);
	cpu_state_t state_q, state_nxt;
	bus_req_t   out_q, req_nxt;
	logic       out_valid_q;
	logic       in_fire;

	// take a beat when the output slot is free or drains this cycle
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign in_fire     = in_ch.valid && in_ch.ready;

	cpu_step u_step (
		.cur     (state_q),
		.restart (in_ch.restart),
		.rd      (in_ch.read_data),
		.nxt     (state_nxt),
		.req     (req_nxt)
	);

	// advance the architectural state once per accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (in_fire) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the payload until a new beat replaces it
	always_ff @(posedge clk) begin
		if (in_fire) out_q <= req_nxt;
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.bus_address      = out_q.bus_address;
	assign out_ch.write_en         = out_q.write_en;
	assign out_ch.write_data       = out_q.write_data;
	assign out_ch.instruction_done = out_q.instruction_done;
	assign out_ch.halted_illegal   = out_q.halted_illegal;

	a_halt_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.halted_illegal) |-> !out_q.write_en)
		else $error("halted core issued a write");

	a_write_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.write_en) |-> !out_q.instruction_done)
		else $error("write access marked as instruction end");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.halt && !(in_fire && in_ch.restart)) |=> state_q.halt)
		else $error("halt dropped without restart");

endmodule
`default_nettype wire

@@ sv/cpu_decode.sv @@
`default_nettype none
module cpu_decode import cpu_pkg::*; (
	input  wire logic [7:0] opc,
	output mode_t           mode,
	output op_t             op
);
	logic [1:0] g;
	logic [2:0] b;
	logic [2:0] a;
	mode_t      m;

	assign g = opc[1:0];
	assign b = opc[4:2];
	assign a = opc[7:5];

	always_comb begin
		mode = M_IMP;
		op   = OP_ILL;
		m    = M_NONE;
		unique case (g)
			2'd1: begin
				if (opc != OPC_STA_IMM) begin
					op = op_t'({2'b00, a});
					unique case (b)
						3'd0: mode = M_IZX;
						3'd1: mode = M_ZP;
						3'd2: mode = M_IMM;
						3'd3: mode = M_ABS;
						3'd4: mode = M_IZY;
						3'd5: mode = M_ZPX;
						3'd6: mode = M_ABY;
						default: mode = M_ABX;
					endcase
				end
			end
			2'd2: begin
				if ((b == 3'd2 && a >= 3'd4) || (b == 3'd6 && (a == 3'd4 || a == 3'd5))) begin
					op = OP_IMPL;
				end else begin
					unique case (b)
						3'd0: m = M_IMM;
						3'd1: m = M_ZP;
						3'd2: m = M_ACC;
						3'd3: m = M_ABS;
						3'd5: m = M_ZPX;
						3'd7: m = M_ABX;
						default: m = M_NONE;
					endcase
					if (a == 3'd4 || a == 3'd5) begin
						if (m == M_ZPX) m = M_ZPY;
						else if (m == M_ABX) m = M_ABY;
					end
					if (!(m == M_NONE || (m == M_IMM && a != 3'd5) ||
					      (a == 3'd4 && m == M_ABY))) begin
						mode = m;
						op   = op_t'(5'd8 + {2'b00, a});
					end
				end
			end
			2'd0: begin
				if (b == 3'd4) begin
					mode = M_REL;
					op   = OP_BRANCH;
				end else if (b == 3'd2 || b == 3'd6) begin
					if (b == 3'd2 && a < 3'd4) op = a[0] ? OP_PULL : OP_PUSH;
					else op = OP_IMPL;
				end else if (b == 3'd0) begin
					unique case (a)
						3'd0: op = OP_BRK;
						3'd1: begin mode = M_ABS; op = OP_JSR; end
						3'd2: op = OP_RTI;
						3'd3: op = OP_RTS;
						3'd5: begin mode = M_IMM; op = OP_LDY; end
						3'd6: begin mode = M_IMM; op = OP_CPY; end
						3'd7: begin mode = M_IMM; op = OP_CPX; end
						default: op = OP_ILL;
					endcase
				end else begin
					unique case (b[2:1])
						2'd0: m = M_ZP;
						2'd1: m = M_ABS;
						2'd2: m = M_ZPX;
						default: m = M_ABX;
					endcase
					unique case (a)
						3'd1: if (b == 3'd1 || b == 3'd3) begin mode = m; op = OP_BIT; end
						3'd2: if (b == 3'd3) begin mode = M_ABS; op = OP_JMP; end
						3'd3: if (b == 3'd3) begin mode = M_IND; op = OP_JMP; end
						3'd4: if (b != 3'd7) begin mode = m; op = OP_STY; end
						3'd5: begin mode = m; op = OP_LDY; end
						3'd6: if (b == 3'd1 || b == 3'd3) begin mode = m; op = OP_CPY; end
						3'd7: if (b == 3'd1 || b == 3'd3) begin mode = m; op = OP_CPX; end
						default: op = OP_ILL;
					endcase
				end
			end
			default: op = OP_ILL;
		endcase
	end
endmodule
`default_nettype wire

@@ sv/cpu_step.sv @@
`default_nettype none
module cpu_step import cpu_pkg::*; (
	input  wire cpu_state_t  cur,
	input  wire logic        restart,
	input  wire logic [7:0]  rd,
	output cpu_state_t       nxt,
	output bus_req_t         req
);
	cpu_state_t s;
	mode_t      md_cur, md_new, md;
	op_t        op_cur, op_new, op;
	logic [15:0] t;
	logic [2:0]  bt;
	logic        bflag;
	logic [8:0]  sum;
	logic [7:0]  v8;

	assign s = restart ? STATE_RESET : cur;

	cpu_decode u_dec_cur (.opc(s.opc), .mode(md_cur), .op(op_cur));
	cpu_decode u_dec_new (.opc(rd), .mode(md_new), .op(op_new));

	function automatic logic [7:0] nz(input logic [7:0] p, input logic [7:0] v);
		logic [7:0] r;
		r = p;
		r[FL_Z] = (v == 8'h00);
		r[FL_N] = v[7];
		return r;
	endfunction

	function automatic logic is_modify(input op_t o);
		return (o == OP_ASL || o == OP_ROL || o == OP_LSR || o == OP_ROR ||
		        o == OP_DEC || o == OP_INC);
	endfunction

	// result byte in the low half, new flags in the high half
	function automatic logic [15:0] modify(input op_t o, input logic [7:0] v,
			input logic [7:0] p);
		logic [7:0] r;
		logic [7:0] f;
		r = v;
		f = p;
		case (o)
			OP_ASL: begin r = {v[6:0], 1'b0};    f[FL_C] = v[7]; end
			OP_ROL: begin r = {v[6:0], p[FL_C]}; f[FL_C] = v[7]; end
			OP_LSR: begin r = {1'b0, v[7:1]};    f[FL_C] = v[0]; end
			OP_ROR: begin r = {p[FL_C], v[7:1]}; f[FL_C] = v[0]; end
			OP_DEC: r = v - 8'd1;
			OP_INC: r = v + 8'd1;
			default: r = v;
		endcase
		return {nz(f, r), r};
	endfunction

	always_comb begin
		nxt = s;
		req = '0;
		md  = md_cur;
		op  = op_cur;
		t   = '0;
		bt  = '0;
		bflag = 1'b0;
		sum = '0;
		v8  = '0;
		if (s.halt) begin
			req.bus_address = s.pc;
		end else begin
			unique case (s.step)
				ST_START: begin
					nxt.ea = RESET_VECTOR;
					req.bus_address = RESET_VECTOR;
					nxt.step = ST_VLO;
				end
				ST_VLO: begin
					nxt.opb = rd;
					req.bus_address = s.ea + 16'd1;
					nxt.step = ST_VHI;
				end
				ST_VHI: begin
					nxt.pc = {rd, s.opb};
					req.bus_address = nxt.pc;
					req.instruction_done = (s.ea == BREAK_VECTOR);
					nxt.step = ST_OPC;
				end
				ST_OPC: begin
					nxt.opc = rd;
					md = md_new;
					op = op_new;
					if (op == OP_ILL) begin
						nxt.halt = 1'b1;
						req.bus_address = s.pc;
						nxt.step = ST_OPC;
					end else begin
						nxt.pc = s.pc + 16'd1;
						nxt.step = ST_OPC;
						req.bus_address = nxt.pc;
						if (op == OP_IMPL) begin
							req.instruction_done = 1'b1;
							case (rd)
								8'h18: nxt.p[FL_C] = 1'b0;
								8'h38: nxt.p[FL_C] = 1'b1;
								8'h58: nxt.p[FL_I] = 1'b0;
								8'h78: nxt.p[FL_I] = 1'b1;
								8'hB8: nxt.p[FL_V] = 1'b0;
								8'hD8: nxt.p[FL_D] = 1'b0;
								8'hF8: nxt.p[FL_D] = 1'b1;
								8'h88: begin nxt.y = s.y - 8'd1; nxt.p = nz(s.p, nxt.y); end
								8'hC8: begin nxt.y = s.y + 8'd1; nxt.p = nz(s.p, nxt.y); end
								8'hCA: begin nxt.x = s.x - 8'd1; nxt.p = nz(s.p, nxt.x); end
								8'hE8: begin nxt.x = s.x + 8'd1; nxt.p = nz(s.p, nxt.x); end
								8'h98: begin nxt.a = s.y; nxt.p = nz(s.p, s.y); end
								8'h8A: begin nxt.a = s.x; nxt.p = nz(s.p, s.x); end
								8'hA8: begin nxt.y = s.a; nxt.p = nz(s.p, s.a); end
								8'hAA: begin nxt.x = s.a; nxt.p = nz(s.p, s.a); end
								8'hBA: begin nxt.x = s.sp; nxt.p = nz(s.p, s.sp); end
								8'h9A: nxt.sp = s.x;
								default: nxt.p = s.p;
							endcase
						end else if (op == OP_PUSH) begin
							req.bus_address = {STACK_PAGE, s.sp};
							req.write_en = 1'b1;
							req.write_data = (rd == OPC_PHA) ? s.a : (s.p | 8'h30);
							nxt.sp = s.sp - 8'd1;
							nxt.step = ST_FIN;
						end else if (op == OP_PULL || op == OP_RTI || op == OP_RTS) begin
							nxt.sp = s.sp + 8'd1;
							req.bus_address = {STACK_PAGE, nxt.sp};
							nxt.step = (op == OP_RTS) ? ST_RLO : ST_PULL;
						end else if (op == OP_BRK) begin
							nxt.pc = s.pc + 16'd2;
							req.bus_address = {STACK_PAGE, s.sp};
							req.write_en = 1'b1;
							req.write_data = nxt.pc[15:8];
							nxt.sp = s.sp - 8'd1;
							nxt.step = ST_PUSHLO;
						end else if (md == M_ACC) begin
							{nxt.p, nxt.a} = modify(op, s.a, s.p);
							req.instruction_done = 1'b1;
						end else begin
							nxt.step = ST_OP1;
						end
					end
				end
				ST_OP1: begin
					nxt.pc = s.pc + 16'd1;
					case (md)
						M_IMM, M_REL: begin
							if (md == M_IMM) begin
								v8 = rd;
							end else begin
								bt = s.opc[7:5];
								case (bt[2:1])
									2'd0: bflag = s.p[FL_N];
									2'd1: bflag = s.p[FL_V];
									2'd2: bflag = s.p[FL_C];
									default: bflag = s.p[FL_Z];
								endcase
								if (bflag == bt[0]) nxt.pc = nxt.pc + {{8{rd[7]}}, rd};
							end
							req.bus_address = nxt.pc;
							req.instruction_done = 1'b1;
							nxt.step = ST_OPC;
						end
						M_ZP, M_ZPX, M_ZPY: begin
							if (md == M_ZP) nxt.ea = {8'h00, rd};
							else if (md == M_ZPX) nxt.ea = {8'h00, rd + s.x};
							else nxt.ea = {8'h00, rd + s.y};
						end
						M_IZX, M_IZY: begin
							nxt.ea = (md == M_IZX) ? {8'h00, rd + s.x} : {8'h00, rd};
							req.bus_address = nxt.ea;
							nxt.step = ST_PLO;
						end
						default: begin
							nxt.opb = rd;
							req.bus_address = nxt.pc;
							nxt.step = ST_OP2;
						end
					endcase
				end
				ST_OP2: begin
					t = {rd, s.opb};
					if (op == OP_JSR) begin
						nxt.ea = t;
						req.bus_address = {STACK_PAGE, s.sp};
						req.write_en = 1'b1;
						req.write_data = s.pc[15:8];
						nxt.sp = s.sp - 8'd1;
						nxt.step = ST_PUSHLO;
					end else begin
						nxt.pc = s.pc + 16'd1;
						if (md == M_ABX) t = t + {8'h00, s.x};
						else if (md == M_ABY) t = t + {8'h00, s.y};
						nxt.ea = t;
						if (op == OP_JMP && md == M_ABS) begin
							nxt.pc = t;
							req.bus_address = t;
							req.instruction_done = 1'b1;
							nxt.step = ST_OPC;
						end else if (md == M_IND) begin
							req.bus_address = t;
							nxt.step = ST_PLO;
						end
					end
				end
				ST_PLO: begin
					nxt.opb = rd;
					if (md == M_IND) req.bus_address = {s.ea[15:8], s.ea[7:0] + 8'd1};
					else req.bus_address = {8'h00, s.ea[7:0] + 8'd1};
					nxt.step = ST_PHI;
				end
				ST_PHI: begin
					t = {rd, s.opb};
					if (md == M_IND) begin
						nxt.pc = t;
						req.bus_address = t;
						req.instruction_done = 1'b1;
						nxt.step = ST_OPC;
					end else begin
						if (md == M_IZY) t = t + {8'h00, s.y};
						nxt.ea = t;
					end
				end
				ST_DATA: begin
					nxt.opb = rd;
					if (is_modify(op)) begin
						req.bus_address = s.ea;
						req.write_en = 1'b1;
						{nxt.p, req.write_data} = modify(op, rd, s.p);
						nxt.step = ST_FIN;
					end else begin
						v8 = rd;
						req.bus_address = s.pc;
						req.instruction_done = 1'b1;
						nxt.step = ST_OPC;
					end
				end
				ST_FIN: begin
					req.bus_address = s.pc;
					req.instruction_done = 1'b1;
					nxt.step = ST_OPC;
				end
				ST_PULL: begin
					if (s.opc == OPC_PLA) begin
						nxt.a = rd;
						nxt.p = nz(s.p, rd);
						req.bus_address = s.pc;
						req.instruction_done = 1'b1;
						nxt.step = ST_OPC;
					end else begin
						nxt.p = (rd & 8'hEF) | 8'h20;
						if (s.opc == OPC_RTI) begin
							nxt.sp = s.sp + 8'd1;
							req.bus_address = {STACK_PAGE, nxt.sp};
							nxt.step = ST_RLO;
						end else begin
							req.bus_address = s.pc;
							req.instruction_done = 1'b1;
							nxt.step = ST_OPC;
						end
					end
				end
				ST_RLO: begin
					nxt.opb = rd;
					nxt.sp = s.sp + 8'd1;
					req.bus_address = {STACK_PAGE, nxt.sp};
					nxt.step = ST_RHI;
				end
				ST_RHI: begin
					t = {rd, s.opb};
					if (s.opc != OPC_RTI) t = t + 16'd1;
					nxt.pc = t;
					req.bus_address = t;
					req.instruction_done = 1'b1;
					nxt.step = ST_OPC;
				end
				ST_PUSHLO: begin
					req.bus_address = {STACK_PAGE, s.sp};
					req.write_en = 1'b1;
					req.write_data = s.pc[7:0];
					nxt.sp = s.sp - 8'd1;
					nxt.step = ST_PUSHP;
					if (s.opc == OPC_JSR) begin
						nxt.pc = s.ea;
						nxt.step = ST_FIN;
					end
				end
				ST_PUSHP: begin
					req.bus_address = {STACK_PAGE, s.sp};
					req.write_en = 1'b1;
					req.write_data = s.p | 8'h30;
					nxt.sp = s.sp - 8'd1;
					nxt.p[FL_I] = 1'b1;
					nxt.step = ST_BVEC;
				end
				default: begin
					nxt.ea = BREAK_VECTOR;
					req.bus_address = BREAK_VECTOR;
					nxt.step = ST_VLO;
				end
			endcase

			// effective address ready: issue the data access
			if ((s.step == ST_OP1 && (md == M_ZP || md == M_ZPX || md == M_ZPY)) ||
			    (s.step == ST_OP2 && op != OP_JSR && !(op == OP_JMP) ) ||
			    (s.step == ST_PHI && md != M_IND)) begin
				req.bus_address = nxt.ea;
				if (op == OP_STA || op == OP_STX || op == OP_STY) begin
					req.write_en = 1'b1;
					req.write_data = (op == OP_STA) ? s.a : (op == OP_STX) ? s.x : s.y;
					nxt.step = ST_FIN;
				end else begin
					nxt.step = ST_DATA;
				end
			end

			// read-type execution for immediate operands and data reads
			if ((s.step == ST_OP1 && md == M_IMM) ||
			    (s.step == ST_DATA && !is_modify(op))) begin
				case (op)
					OP_ORA: begin nxt.a = s.a | v8; nxt.p = nz(s.p, nxt.a); end
					OP_AND: begin nxt.a = s.a & v8; nxt.p = nz(s.p, nxt.a); end
					OP_EOR: begin nxt.a = s.a ^ v8; nxt.p = nz(s.p, nxt.a); end
					OP_ADC, OP_SBC: begin
						if (op == OP_SBC) v8 = ~v8;
						sum = {1'b0, s.a} + {1'b0, v8} + {8'h00, s.p[FL_C]};
						nxt.a = sum[7:0];
						nxt.p = nz(s.p, sum[7:0]);
						nxt.p[FL_C] = sum[8];
						nxt.p[FL_V] = ~(s.a[7] ^ v8[7]) & (s.a[7] ^ sum[7]);
					end
					OP_LDA: begin nxt.a = v8; nxt.p = nz(s.p, v8); end
					OP_LDX: begin nxt.x = v8; nxt.p = nz(s.p, v8); end
					OP_LDY: begin nxt.y = v8; nxt.p = nz(s.p, v8); end
					OP_CMP, OP_CPX, OP_CPY: begin
						t[7:0] = (op == OP_CMP) ? s.a : (op == OP_CPX) ? s.x : s.y;
						sum = {1'b0, t[7:0]} - {1'b0, v8};
						nxt.p = nz(s.p, sum[7:0]);
						nxt.p[FL_C] = (t[7:0] >= v8);
					end
					OP_BIT: begin
						nxt.p[FL_Z] = ((s.a & v8) == 8'h00);
						nxt.p[FL_N] = v8[7];
						nxt.p[FL_V] = v8[6];
					end
					default: nxt.p = s.p;
				endcase
			end
		end
		req.halted_illegal = nxt.halt;
	end
endmodule
`default_nettype wire
